// ----- rtl/first_fit_heap_allocator_assert.svh -----
// Assertion macros for the first-fit heap allocator.
// Users must have clk and rst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// same-cycle implication
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit heap allocator: constants, codes, fit unit types.
// No dependencies.
`default_nettype none
package ffa_pkg;
    localparam int FFA_MAX_BLOCKS = 16;
    localparam int HEADER_BYTES   = 16;
    localparam int ALIGN_BYTES    = 8;
    localparam int SIZE_W         = 24;
    localparam int ADDR_W         = 32;
    localparam int EXT_W          = 34;
    localparam int ENTRY_W        = ADDR_W + SIZE_W;
    localparam int CFG_IDX_W      = 2;

    localparam logic [EXT_W-1:0] HDR_EXT    = EXT_W'(HEADER_BYTES);
    localparam logic [EXT_W-1:0] ALIGN_ADD  = EXT_W'(ALIGN_BYTES - 1);
    localparam logic [EXT_W-1:0] ALIGN_MASK = ~ALIGN_ADD;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic               fits;
        logic               match;
        logic [ADDR_W-1:0]  cand_hdr;
        logic [ADDR_W-1:0]  cand_data;
        logic [EXT_W-1:0]   next_end;
    } fit_res_t;
endpackage
`default_nettype wire

// ----- rtl/ffa_if.sv -----
// Channel interfaces: request, response and configuration write.
// Uses ffa_pkg.
`default_nettype none
interface ffa_req_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
    modport source (output valid, action, request_size, free_address, input ready);
    modport sink   (input valid, action, request_size, free_address, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data_address;
    logic [1:0]        status;
    modport source (output valid, data_address, status, input ready);
    modport sink   (input valid, data_address, status, output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                  wr_data,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                  rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/ffa_fit.sv -----
// Shared address unit: candidate header, fit compare, chain advance, free match.
// Uses ffa_pkg.
`default_nettype none
module ffa_fit import ffa_pkg::*; (
    input  wire logic [EXT_W-1:0]  cur_end,
    input  wire logic [SIZE_W-1:0] req_size,
    input  wire logic [ADDR_W-1:0] free_addr,
    input  wire logic [ADDR_W-1:0] ent_hdr,
    input  wire logic [SIZE_W-1:0] ent_size,
    input  wire logic [ADDR_W-1:0] heap_limit,
    input  wire logic              is_last,
    output fit_res_t               res
);
    logic [EXT_W-1:0] hdr;
    logic [EXT_W-1:0] data;
    logic [EXT_W-1:0] cand_end;
    logic [EXT_W-1:0] ent_data;

    always_comb
    begin
        hdr      = (cur_end + ALIGN_ADD) & ALIGN_MASK;
        data     = hdr + HDR_EXT;
        cand_end = data + EXT_W'(req_size);
        ent_data = EXT_W'(ent_hdr) + HDR_EXT;
        res.fits = is_last ? (cand_end < EXT_W'(heap_limit))
                           : (cand_end <= EXT_W'(ent_hdr));
        res.match     = (ent_data == EXT_W'(free_addr));
        res.cand_hdr  = hdr[ADDR_W-1:0];
        res.cand_data = data[ADDR_W-1:0];
        res.next_end  = ent_data + EXT_W'(ent_size);
    end
endmodule
`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// Allocate: walk entries until one fits, shift any later entries up, insert, then DONE.
// Free: walk to the matching entry, shift any later entries down, then DONE. Table
// full: straight to DONE. DONE waits while rsp is stalled. Result is registered; one
// request in flight, next accepted once the beat is loaded. Async active-low reset
// empties the table, heap_base 0, heap_limit 65536.
`default_nettype none
module first_fit_heap_allocator import ffa_pkg::*; #(
    parameter int MAX_BLOCKS = FFA_MAX_BLOCKS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp,
    ffa_cfg_if.sink   cfg
);
    `include "first_fit_heap_allocator_assert.svh"

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AWALK = 7'b0000010,
        S_FWALK = 7'b0000100,
        S_SHUP  = 7'b0001000,
        S_SHDN  = 7'b0010000,
        S_INS   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     k_reg, k_next, j_reg, j_next, count_reg, count_next;
    logic [EXT_W-1:0]  cur_end_reg, cur_end_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, hdr_reg, hdr_next;
    logic [ADDR_W-1:0] res_data_reg, res_data_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_data_reg, out_data_next;
    logic [1:0]        out_st_reg, out_st_next;
    logic [ADDR_W-1:0] base_reg, limit_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [CW-1:0]      rd_idx;
    fit_res_t           fit;
    logic               req_beat;

    ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    ffa_fit u_fit (
        .cur_end(cur_end_reg), .req_size(size_reg), .free_addr(addr_reg),
        .ent_hdr(rd_data[ENTRY_W-1:SIZE_W]), .ent_size(rd_data[SIZE_W-1:0]),
        .heap_limit(limit_reg), .is_last(k_reg == count_reg), .res(fit)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_beat  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data_address = out_data_reg;
    assign rsp.status = out_st_reg;
    assign cfg.ready = 1'b1;
    assign rd_addr = rd_idx[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        j_next = j_reg;
        count_next = count_reg;
        cur_end_next = cur_end_reg;
        size_next = size_reg;
        addr_next = addr_reg;
        hdr_next = hdr_reg;
        res_data_next = res_data_reg;
        res_st_next = res_st_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next = out_data_reg;
        out_st_next = out_st_reg;
        rd_idx = k_reg;
        wr_en = 1'b0;
        wr_addr = j_reg[AW-1:0];
        wr_data = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                rd_idx = '0;
                if (req_beat)
                begin
                    k_next = '0;
                    size_next = req.request_size;
                    addr_next = req.free_address;
                    cur_end_next = EXT_W'(base_reg) + HDR_EXT;
                    res_data_next = '0;
                    if (req.action == ACT_FREE)
                    begin
                        state_next = S_FWALK;
                    end
                    else if (count_reg == CNT_MAX)
                    begin
                        res_st_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_AWALK;
                    end
                end
            end
            S_AWALK:
            begin
                if (fit.fits)
                begin
                    hdr_next = fit.cand_hdr;
                    res_data_next = fit.cand_data;
                    if (k_reg == count_reg)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        rd_idx = count_reg - CW'(1);
                        j_next = count_reg;
                        state_next = S_SHUP;
                    end
                end
                else if (k_reg == count_reg)
                begin
                    res_st_next = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_end_next = fit.next_end;
                    k_next = k_reg + CW'(1);
                    rd_idx = k_reg + CW'(1);
                end
            end
            S_SHUP:
            begin
                wr_en = 1'b1;
                if (j_reg - CW'(1) == k_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    rd_idx = j_reg - CW'(2);
                    j_next = j_reg - CW'(1);
                end
            end
            S_INS:
            begin
                wr_en = 1'b1;
                wr_addr = k_reg[AW-1:0];
                wr_data = {hdr_reg, size_reg};
                count_next = count_reg + CW'(1);
                res_st_next = ST_OK;
                state_next = S_DONE;
            end
            S_FWALK:
            begin
                if (k_reg == count_reg)
                begin
                    res_st_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else if (fit.match)
                begin
                    res_st_next = ST_OK;
                    if (k_reg + CW'(1) == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_idx = k_reg + CW'(1);
                        j_next = k_reg;
                        state_next = S_SHDN;
                    end
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    rd_idx = k_reg + CW'(1);
                end
            end
            S_SHDN:
            begin
                wr_en = 1'b1;
                if (j_reg + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_idx = j_reg + CW'(2);
                    j_next = j_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = res_data_reg;
                    out_st_next = res_st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            base_reg <= '0;
            limit_reg <= 32'd65536;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.index == CFG_HEAP_BASE)
            begin
                base_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == CFG_HEAP_LIMIT)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        j_reg <= j_next;
        cur_end_reg <= cur_end_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
        hdr_reg <= hdr_next;
        res_data_reg <= res_data_next;
        res_st_reg <= res_st_next;
        out_data_reg <= out_data_next;
        out_st_reg <= out_st_next;
    end

    `FFA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_MAX, "block count above table size")
    `FFA_ASSERT_NOW(a_err_zero, out_valid_reg && out_st_reg != ST_OK, out_data_reg == '0,
        "error result carries an address")
    `FFA_ASSERT_NXT(a_count_step, state_reg != S_INS && state_reg != S_FWALK
        && state_reg != S_SHDN, count_reg == $past(count_reg), "count moved outside update")
    `FFA_ASSERT_NXT(a_ins_grow, state_reg == S_INS, count_reg == $past(count_reg) + CW'(1),
        "insert did not grow table")
endmodule
`default_nettype wire
